// ===== rtl/core/tkpt_pkg.sv =====
// ----------------------------------------------------------------------------
// tkpt_pkg
// shared types and constants of the three key press timer
// ----------------------------------------------------------------------------
package tkpt_pkg;

  localparam int unsigned NUM_KEYS  = 3;
  localparam int unsigned KEY_COUNT = 3;

  localparam int unsigned TIME_W = 32;
  localparam int unsigned DEB_W  = 8;

  localparam logic [DEB_W-1:0] DEBOUNCE_RESET = 8'd20;

  localparam int unsigned IN_FIELDS_W  = TIME_W + KEY_COUNT;
  localparam int unsigned IN_TDATA_W   = ((IN_FIELDS_W + 7) / 8) * 8;
  localparam int unsigned OUT_FIELDS_W = 1 + KEY_COUNT * TIME_W + 2 * KEY_COUNT;
  localparam int unsigned OUT_TDATA_W  = ((OUT_FIELDS_W + 7) / 8) * 8;

  localparam int unsigned IDX_ENTER = 0;
  localparam int unsigned IDX_DOWN  = 1;
  localparam int unsigned IDX_UP    = 2;

  typedef struct packed {
    logic [TIME_W-1:0] hold_time;
    logic              rise;
    logic              fall;
  } key_res_t;

endpackage

// ===== rtl/core/tkpt_key.sv =====
// ----------------------------------------------------------------------------
// tkpt_key
// press latch, start time and edge flags of one key
// ----------------------------------------------------------------------------
module tkpt_key (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            adv,
  input  logic                            level,
  input  logic [tkpt_pkg::TIME_W-1:0]     now_ms,
  input  logic [tkpt_pkg::DEB_W-1:0]      debounce_ms,
  output tkpt_pkg::key_res_t              res
);

  logic                        latched_r;
  logic                        latched_nxt;
  logic [tkpt_pkg::TIME_W-1:0] start_r;
  logic [tkpt_pkg::TIME_W-1:0] start_nxt;
  logic [tkpt_pkg::TIME_W-1:0] start_eff;
  logic [tkpt_pkg::TIME_W-1:0] elapsed;
  logic [tkpt_pkg::TIME_W-1:0] deb_ext;

  assign start_eff = latched_r ? start_r : now_ms;
  assign elapsed   = now_ms - start_eff;
  assign deb_ext   = {{(tkpt_pkg::TIME_W - tkpt_pkg::DEB_W){1'b0}}, debounce_ms};

  always_comb begin
    res.rise      = level & ~latched_r;
    res.fall      = ~level & latched_r;
    res.hold_time = '0;
    if (level) begin
      res.hold_time = (elapsed > deb_ext) ? elapsed : {{(tkpt_pkg::TIME_W-1){1'b0}}, 1'b1};
    end
    latched_nxt = level;
    start_nxt   = level ? start_eff : '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      latched_r <= 1'b0;
      start_r   <= '0;
    end else if (adv) begin
      latched_r <= latched_nxt;
      start_r   <= start_nxt;
    end
  end

endmodule

// ===== rtl/core/three_key_press_timer_core.sv =====
// ----------------------------------------------------------------------------
// three_key_press_timer_core
// press duration and edge flags for the enter, down and up keys
// ----------------------------------------------------------------------------
// in_* carries one sample item: a millisecond tick and three raw key levels.
// out_* carries one result item per sample: any key pressed, the hold time
// of each key (0 released, 1 not yet past debounce, else held ms) and a
// rise and fall flag per key. cfg_wr_en writes debounce_ms at once.
// an item passes an input register and a result register: out_tvalid rises
// when the item moves from the input register into the result register.
// one item per cycle is sustained while out_tready stays high, set by the
// single compare and subtract per key between the two registers, with the
// key state updated as an item leaves the input register.
// reset clears all key latches and start times, empties both registers and
// sets debounce_ms to 20. when the receiver stalls, the result register holds
// its item and the input register still takes one more; in_tready falls only
// when both are full.
// ----------------------------------------------------------------------------
module three_key_press_timer_core (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_wr_en,
  input  logic [tkpt_pkg::DEB_W-1:0]          cfg_wr_data,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  // now_ms[31:0], enter_level, down_level, up_level, zero fill
  input  logic [tkpt_pkg::IN_TDATA_W-1:0]     in_tdata,
  output logic                                out_tvalid,
  input  logic                                out_tready,
  // any_pressed, enter_time, down_time, up_time, enter_rise, enter_fall,
  // down_rise, down_fall, up_rise, up_fall, zero fill
  output logic [tkpt_pkg::OUT_TDATA_W-1:0]    out_tdata
);

  logic [tkpt_pkg::DEB_W-1:0]     debounce_r;
  logic                           s1_valid_r;
  logic [tkpt_pkg::TIME_W-1:0]    s1_now_r;
  logic [tkpt_pkg::KEY_COUNT-1:0] s1_level_r;
  logic                           s1_adv;
  logic                           out_valid_r;
  logic [tkpt_pkg::OUT_TDATA_W-1:0] out_data_r;
  logic [tkpt_pkg::OUT_TDATA_W-1:0] out_data_nxt;
  tkpt_pkg::key_res_t             key_res [tkpt_pkg::KEY_COUNT];

  assign s1_adv    = s1_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !s1_valid_r || s1_adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      debounce_r <= tkpt_pkg::DEBOUNCE_RESET;
    end else if (cfg_wr_en) begin
      debounce_r <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_tready) begin
      s1_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      s1_now_r   <= in_tdata[tkpt_pkg::TIME_W-1:0];
      s1_level_r <= in_tdata[tkpt_pkg::TIME_W +: tkpt_pkg::KEY_COUNT];
    end
  end

  for (genvar k = 0; k < tkpt_pkg::KEY_COUNT; k++) begin : g_key
    if (k < tkpt_pkg::NUM_KEYS) begin : g_on
      tkpt_key u_key (
        .clk         (clk),
        .rst_n       (rst_n),
        .adv         (s1_adv),
        .level       (s1_level_r[k]),
        .now_ms      (s1_now_r),
        .debounce_ms (debounce_r),
        .res         (key_res[k])
      );
    end else begin : g_off
      assign key_res[k] = '0;
    end
  end

  always_comb begin
    out_data_nxt    = '0;
    out_data_nxt[0] = |s1_level_r;
    for (int k = 0; k < tkpt_pkg::KEY_COUNT; k++) begin
      out_data_nxt[1 + k*tkpt_pkg::TIME_W +: tkpt_pkg::TIME_W] = key_res[k].hold_time;
      out_data_nxt[1 + tkpt_pkg::KEY_COUNT*tkpt_pkg::TIME_W + 2*k]     = key_res[k].rise;
      out_data_nxt[1 + tkpt_pkg::KEY_COUNT*tkpt_pkg::TIME_W + 2*k + 1] = key_res[k].fall;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (!out_valid_r || out_tready) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

// ===== rtl/core/tkpt_checker.sv =====
// ----------------------------------------------------------------------------
// tkpt_checker
// port level checks of the three key press timer
// ----------------------------------------------------------------------------
module tkpt_checker (
  input logic                             clk,
  input logic                             rst_n,
  input logic                             in_tready,
  input logic                             out_tvalid,
  input logic                             out_tready,
  input logic [tkpt_pkg::OUT_TDATA_W-1:0] out_tdata
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("result item dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> $stable(out_tdata))
    else $error("stalled result item changed");

  a_reset_empty: assert property (@(posedge clk)
    $past(!rst_n) |-> !out_tvalid && in_tready)
    else $error("pipeline not empty after reset");

  a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_tvalid |-> in_tready)
    else $error("input stalled with result register empty");

endmodule

bind three_key_press_timer_core tkpt_checker u_tkpt_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);
